### rtl/ccssa_pkg.sv
`default_nettype none

package ccssa_pkg;

    localparam int MAX_COLUMNS_DEF = 64;
    localparam int VALUE_BITS_DEF  = 32;

    localparam int COLUMN_W = 6;
    localparam int DATA_W   = 32;
    localparam int SUM_W    = 48;
    localparam int SQ_W     = 63;
    localparam int CFG_W    = 7;
    localparam int PADDR_W  = 2;
    localparam int PDATA_W  = 32;

    localparam logic [CFG_W-1:0]   COLUMNS_RESET = 7'd64;
    localparam logic [PADDR_W-1:0] ADDR_COLUMNS_IN_USE = 2'd0;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic [SQ_W-1:0]         SQ_MAX  = {SQ_W{1'b1}};

    typedef enum logic
    {
        OP_ACCUMULATE = 1'b0,
        OP_READ       = 1'b1
    } op_t;

    typedef struct packed
    {
        op_t                       op;
        logic [COLUMN_W-1:0]       column;
        logic signed [DATA_W-1:0]  element_value;
        logic signed [DATA_W-1:0]  clip_limit;
    } in_item_t;

    typedef struct packed
    {
        logic [COLUMN_W-1:0]       out_column;
        logic signed [SUM_W-1:0]   clipped_sum;
        logic [SQ_W-1:0]           clipped_sum_of_squares;
    } result_t;

endpackage

`default_nettype wire

### rtl/column_clip_sum_and_square_accumulator.sv
`default_nettype none

// Per-column clipped sum and sum of squares. An item is taken on any cycle where start is
// high and busy is low, so one item per clock is sustained. A read item gives its result on
// done/result through the input register with the clip, then the multiply and store read
// register, then the output register; accumulate items give no result. The receiver cannot
// stall: done is high for one cycle only. After reset busy stays high while a clearing pass
// zeroes the column store; the APB port is usable throughout. Back-to-back items on the same
// column are handled by forwarding.
module column_clip_sum_and_square_accumulator
    import ccssa_pkg::*;
#(
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
    parameter int VALUE_BITS  = VALUE_BITS_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,

    input  wire logic                start,
    output logic                     busy,
    input  wire in_item_t            item,

    output logic                     done,
    output result_t                  result,

    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [PADDR_W-1:0]  paddr,
    input  wire logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]       prdata,
    output logic                     pready
);

    localparam int ADDR_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int PROD_W = 2 * VALUE_BITS;

    // configuration
    logic [CFG_W-1:0] columns_reg;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_COLUMNS_IN_USE) ? PDATA_W'(columns_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            columns_reg <= COLUMNS_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr == ADDR_COLUMNS_IN_USE))
        begin
            columns_reg <= pwdata[CFG_W-1:0];
        end
    end

    // clearing pass
    logic              clearing_reg;
    logic [ADDR_W-1:0] clr_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clearing_reg)
        begin
            if (clr_addr_reg == ADDR_W'(MAX_COLUMNS - 1))
            begin
                clearing_reg <= 1'b0;
            end
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    assign busy = clearing_reg;

    // input decode
    logic                          accept;
    logic                          col_in_store;
    logic                          col_ok;
    logic signed [VALUE_BITS-1:0]  in_val;
    logic signed [VALUE_BITS-1:0]  in_clip;
    logic signed [VALUE_BITS-1:0]  in_c;
    logic signed [VALUE_BITS-1:0]  in_c_neg;
    logic [ADDR_W-1:0]             rd_addr;

    assign accept       = start && !busy;
    assign col_in_store = (32'(item.column) < MAX_COLUMNS);
    assign col_ok       = col_in_store && (CFG_W'(item.column) < columns_reg);
    assign in_val       = item.element_value[VALUE_BITS-1:0];
    assign in_clip      = item.clip_limit[VALUE_BITS-1:0];
    assign in_c         = (in_val < in_clip) ? in_val : in_clip;
    assign in_c_neg     = -in_c;
    assign rd_addr      = ADDR_W'(item.column);

    // stage 1: clipped value and magnitude
    logic                          s1_valid_reg;
    op_t                           s1_op_reg;
    logic [COLUMN_W-1:0]           s1_col_reg;
    logic                          s1_in_store_reg;
    logic signed [VALUE_BITS-1:0]  s1_c_reg;
    logic [VALUE_BITS-1:0]         s1_mag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept && ((item.op == OP_READ) || col_ok);
        end
    end

    always_ff @(posedge clk)
    begin
        s1_op_reg       <= item.op;
        s1_col_reg      <= item.column;
        s1_in_store_reg <= col_in_store;
        s1_c_reg        <= in_c;
        s1_mag_reg      <= in_c[VALUE_BITS-1] ? unsigned'(in_c_neg) : unsigned'(in_c);
    end

    // column store
    logic signed [SUM_W-1:0] sum_mem [MAX_COLUMNS];
    logic [SQ_W-1:0]         sq_mem  [MAX_COLUMNS];
    logic signed [SUM_W-1:0] rd_sum_reg;
    logic [SQ_W-1:0]         rd_sq_reg;
    logic                    mem_we;
    logic [ADDR_W-1:0]       mem_addr;
    logic signed [SUM_W-1:0] mem_sum;
    logic [SQ_W-1:0]         mem_sq;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            sum_mem[mem_addr] <= mem_sum;
            sq_mem[mem_addr]  <= mem_sq;
        end
        rd_sum_reg <= sum_mem[rd_addr];
        rd_sq_reg  <= sq_mem[rd_addr];
    end

    // stage 2: accumulate and write back
    logic                          s2_valid_reg;
    op_t                           s2_op_reg;
    logic [COLUMN_W-1:0]           s2_col_reg;
    logic                          s2_in_store_reg;
    logic signed [VALUE_BITS-1:0]  s2_c_reg;
    logic [PROD_W-1:0]             s2_prod_reg;
    logic signed [SUM_W-1:0]       s2_sum_old_reg;
    logic [SQ_W-1:0]               s2_sq_old_reg;

    logic signed [SUM_W:0]   sum_wide;
    logic signed [SUM_W-1:0] sum_sat;
    logic [SQ_W:0]           sq_wide;
    logic [SQ_W-1:0]         sq_sat;
    logic                    s2_we;
    logic signed [SUM_W-1:0] s2_new_sum;
    logic [SQ_W-1:0]         s2_new_sq;

    always_comb
    begin
        sum_wide = (SUM_W + 1)'(s2_sum_old_reg) + (SUM_W + 1)'(s2_c_reg);
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1])
        begin
            sum_sat = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
        end
        else
        begin
            sum_sat = sum_wide[SUM_W-1:0];
        end
        sq_wide = {1'b0, s2_sq_old_reg} + (SQ_W + 1)'(s2_prod_reg);
        sq_sat  = sq_wide[SQ_W] ? SQ_MAX : sq_wide[SQ_W-1:0];
    end

    assign s2_we      = s2_valid_reg && s2_in_store_reg;
    assign s2_new_sum = (s2_op_reg == OP_READ) ? '0 : sum_sat;
    assign s2_new_sq  = (s2_op_reg == OP_READ) ? '0 : sq_sat;

    assign mem_we   = clearing_reg || s2_we;
    assign mem_addr = clearing_reg ? clr_addr_reg : ADDR_W'(s2_col_reg);
    assign mem_sum  = clearing_reg ? '0 : s2_new_sum;
    assign mem_sq   = clearing_reg ? '0 : s2_new_sq;

    // last write, for an item whose read coincided with it
    logic                    lw_valid_reg;
    logic [COLUMN_W-1:0]     lw_col_reg;
    logic signed [SUM_W-1:0] lw_sum_reg;
    logic [SQ_W-1:0]         lw_sq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lw_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            lw_valid_reg <= s2_we;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        lw_col_reg <= s2_col_reg;
        lw_sum_reg <= s2_new_sum;
        lw_sq_reg  <= s2_new_sq;
    end

    logic signed [SUM_W-1:0] s2_sum_old_next;
    logic [SQ_W-1:0]         s2_sq_old_next;

    always_comb
    begin
        if (s2_we && (s2_col_reg == s1_col_reg))
        begin
            s2_sum_old_next = s2_new_sum;
            s2_sq_old_next  = s2_new_sq;
        end
        else if (lw_valid_reg && (lw_col_reg == s1_col_reg))
        begin
            s2_sum_old_next = lw_sum_reg;
            s2_sq_old_next  = lw_sq_reg;
        end
        else
        begin
            s2_sum_old_next = rd_sum_reg;
            s2_sq_old_next  = rd_sq_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_op_reg       <= s1_op_reg;
        s2_col_reg      <= s1_col_reg;
        s2_in_store_reg <= s1_in_store_reg;
        s2_c_reg        <= s1_c_reg;
        s2_prod_reg     <= s1_mag_reg * s1_mag_reg;
        s2_sum_old_reg  <= s2_sum_old_next;
        s2_sq_old_reg   <= s2_sq_old_next;
    end

    // result register
    logic    done_reg;
    result_t result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= s2_valid_reg && (s2_op_reg == OP_READ);
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg.out_column             <= s2_col_reg;
        result_reg.clipped_sum            <= s2_in_store_reg ? s2_sum_old_reg : '0;
        result_reg.clipped_sum_of_squares <= s2_in_store_reg ? s2_sq_old_reg : '0;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // checks
    a_no_work_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> !s1_valid_reg && !s2_valid_reg)
        else $error("item in flight during clearing pass");

    a_done_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept && (item.op == OP_READ), 3))
        else $error("result without a read three cycles earlier");

    a_write_in_store: assert property (@(posedge clk) disable iff (!rst_n)
        s2_we |-> (32'(s2_col_reg) < MAX_COLUMNS))
        else $error("write beyond column store");

    a_outside_store_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (32'(result.out_column) >= MAX_COLUMNS)) |->
            (result.clipped_sum == '0) && (result.clipped_sum_of_squares == '0))
        else $error("read beyond store returned data");

    a_read_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_we && (s2_op_reg == OP_READ)) |-> (mem_sum == '0) && (mem_sq == '0))
        else $error("read did not clear column");

endmodule

`default_nettype wire

### sim/tb.sv
`timescale 1ns / 100ps

module tb;
    import ccssa_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_ITEMS  = 120;
    localparam int NUM_PHASES   = 5;
    localparam int NUM_ROWS     = 19;

    typedef struct packed
    {
        op_t                      op;
        logic [COLUMN_W-1:0]      column;
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] clip;
        int                       reps;
        bit                       typed;
        logic signed [SUM_W-1:0]  sum;
        logic [SQ_W-1:0]          sq;
    } dir_row_t;

    // typed rows carry their expected result; the rest go through the predictor
    dir_row_t directed_rows [NUM_ROWS] = '{
        '{OP_READ,       6'd0,  32'sd0,            32'sd0,            1,     1'b1,
          48'sd0,          63'd0},
        '{OP_READ,       6'd63, 32'sd0,            32'sd0,            1,     1'b1,
          48'sd0,          63'd0},
        '{OP_ACCUMULATE, 6'd5,  32'sh7FFF_FFFF,    32'sh7FFF_FFFF,    1,     1'b0,
          48'sd0,          63'd0},
        '{OP_ACCUMULATE, 6'd5,  32'sh8000_0000,    32'sh7FFF_FFFF,    1,     1'b0,
          48'sd0,          63'd0},
        '{OP_READ,       6'd5,  32'sd0,            32'sd0,            1,     1'b0,
          48'sd0,          63'd0},
        '{OP_READ,       6'd5,  32'sd0,            32'sd0,            1,     1'b1,
          48'sd0,          63'd0},
        '{OP_ACCUMULATE, 6'd7,  32'sd100,          -32'sd5,           1,     1'b0,
          48'sd0,          63'd0},
        '{OP_ACCUMULATE, 6'd7,  -32'sd3,           32'sd10,           1,     1'b0,
          48'sd0,          63'd0},
        '{OP_ACCUMULATE, 6'd7,  -32'sd7,           -32'sd7,           1,     1'b0,
          48'sd0,          63'd0},
        '{OP_READ,       6'd7,  32'sd0,            32'sd0,            1,     1'b1,
          -48'sd15,        63'd83},
        '{OP_ACCUMULATE, 6'd9,  32'sh8000_0000,    32'sh7FFF_FFFF,    2,     1'b0,
          48'sd0,          63'd0},
        '{OP_READ,       6'd9,  32'sd0,            32'sd0,            1,     1'b1,
          -48'sd4294967296, SQ_MAX},
        '{OP_ACCUMULATE, 6'd10, 32'sh7FFF_FFFF,    32'sh7FFF_FFFF,    4,     1'b0,
          48'sd0,          63'd0},
        '{OP_ACCUMULATE, 6'd10, -32'sh0001_0000,   32'sd0,            1,     1'b0,
          48'sd0,          63'd0},
        '{OP_READ,       6'd10, 32'sd0,            32'sd0,            1,     1'b0,
          48'sd0,          63'd0},
        '{OP_ACCUMULATE, 6'd63, 32'sh1234_5678,    32'sh0001_0000,    1,     1'b0,
          48'sd0,          63'd0},
        '{OP_READ,       6'd63, 32'sd0,            32'sd0,            1,     1'b0,
          48'sd0,          63'd0},
        '{OP_ACCUMULATE, 6'd0,  32'sh8000_0000,    32'sh8000_0000,    3,     1'b0,
          48'sd0,          63'd0},
        '{OP_READ,       6'd0,  32'sd0,            32'sd0,            1,     1'b1,
          -48'sd6442450944, SQ_MAX}
    };

    int phase_cols [NUM_PHASES] = '{1, 127, 0, 37, 64};
    int phase_idle [NUM_PHASES] = '{0, 50, 11, 50, 0};

    logic                clk = 1'b0;
    logic                rst_n;
    logic                start;
    logic                busy;
    in_item_t            item_in;
    logic                done;
    result_t             result_out;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    logic signed [SUM_W-1:0] col_sum [MAX_COLUMNS_DEF];
    logic [SQ_W-1:0]         col_sq_sum [MAX_COLUMNS_DEF];
    logic [CFG_W-1:0]        cols_cfg;

    result_t pending_results [$];
    result_t want;
    int      xfer_count  = 0;
    int      cycle_count = 0;
    int      fail_count  = 0;

    column_clip_sum_and_square_accumulator u_dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .item    (item_in),
        .done    (done),
        .result  (result_out),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (start && !busy)
        begin
            xfer_count <= xfer_count + 1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result for column %0d", result_out.out_column);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (result_out.out_column !== want.out_column)
                begin
                    $error("out_column: expected %0d, got %0d",
                           want.out_column, result_out.out_column);
                    fail_count++;
                end
                if (result_out.clipped_sum !== want.clipped_sum)
                begin
                    $error("clipped_sum: expected %0d, got %0d",
                           want.clipped_sum, result_out.clipped_sum);
                    fail_count++;
                end
                if (result_out.clipped_sum_of_squares !== want.clipped_sum_of_squares)
                begin
                    $error("clipped_sum_of_squares: expected %0d, got %0d",
                           want.clipped_sum_of_squares, result_out.clipped_sum_of_squares);
                    fail_count++;
                end
            end
        end
    end

    // returns 1 when the item produces a result
    function automatic bit clip_accumulate(input in_item_t it, output result_t res);
        logic [CFG_W-1:0]        lim;
        logic signed [DATA_W-1:0] c;
        logic signed [63:0]      s;
        logic signed [63:0]      cw;
        logic [63:0]             mag;
        logic [63:0]             sq;
        res = '0;
        lim = (cols_cfg < CFG_W'(MAX_COLUMNS_DEF)) ? cols_cfg : CFG_W'(MAX_COLUMNS_DEF);
        if (it.op == OP_ACCUMULATE)
        begin
            if ({1'b0, it.column} >= lim)
            begin
                return 1'b0;
            end
            c = (it.element_value < it.clip_limit) ? it.element_value : it.clip_limit;
            s = col_sum[it.column] + c;
            if (s > SUM_MAX)
            begin
                s = SUM_MAX;
            end
            if (s < SUM_MIN)
            begin
                s = SUM_MIN;
            end
            col_sum[it.column] = s[SUM_W-1:0];
            cw = c;
            mag = (cw < 0) ? -cw : cw;
            sq = mag * mag + {1'b0, col_sq_sum[it.column]};
            if (sq > {1'b0, SQ_MAX})
            begin
                sq = {1'b0, SQ_MAX};
            end
            col_sq_sum[it.column] = sq[SQ_W-1:0];
            return 1'b0;
        end
        res.out_column             = it.column;
        res.clipped_sum            = col_sum[it.column];
        res.clipped_sum_of_squares = col_sq_sum[it.column];
        col_sum[it.column]    = '0;
        col_sq_sum[it.column] = '0;
        return 1'b1;
    endfunction

    function automatic logic signed [DATA_W-1:0] rand_value();
        case ($urandom_range(0, 5))
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFF;
            2: return DATA_W'($signed($urandom_range(0, 32'h4_0000)) - 32'sh2_0000);
            default: return $urandom;
        endcase
    endfunction

    function automatic in_item_t random_item();
        in_item_t it;
        int       span;
        span = (cols_cfg == 0) ? 8 : ((cols_cfg > MAX_COLUMNS_DEF) ? MAX_COLUMNS_DEF : cols_cfg);
        if (span > 8)
        begin
            span = 8;
        end
        it.op = ($urandom_range(0, 99) < 20) ? OP_READ : OP_ACCUMULATE;
        it.column = ($urandom_range(0, 99) < 60) ? COLUMN_W'($urandom_range(0, span - 1))
                                                 : COLUMN_W'($urandom);
        it.element_value = rand_value();
        case ($urandom_range(0, 3))
            0: it.clip_limit = 32'sh7FFF_FFFF;
            1: it.clip_limit = it.element_value;
            default: it.clip_limit = rand_value();
        endcase
        return it;
    endfunction

    task automatic send_item(input in_item_t it, input int idle_pct, input bit typed,
                             input result_t typed_res);
        int      seen;
        result_t res;
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start = 1'b0;
            @(negedge clk);
        end
        start   = 1'b1;
        item_in = it;
        seen    = xfer_count;
        do
            @(negedge clk);
        while (xfer_count == seen);
        if (clip_accumulate(it, res))
        begin
            pending_results.push_back(typed ? typed_res : res);
        end
    endtask

    task automatic drain();
        start = 1'b0;
        while (pending_results.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_columns(input int value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = ADDR_COLUMNS_IN_USE;
        pwdata  = PDATA_W'(value);
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        cols_cfg = CFG_W'(value);
    endtask

    initial
    begin
        in_item_t it;
        result_t  typed_res;
        rst_n   = 1'b0;
        start   = 1'b0;
        item_in = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        cols_cfg = COLUMNS_RESET;
        for (int i = 0; i < MAX_COLUMNS_DEF; i++)
        begin
            col_sum[i]    = '0;
            col_sq_sum[i] = '0;
        end
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[r])
        begin
            it.op            = directed_rows[r].op;
            it.column        = directed_rows[r].column;
            it.element_value = directed_rows[r].value;
            it.clip_limit    = directed_rows[r].clip;
            typed_res.out_column             = directed_rows[r].column;
            typed_res.clipped_sum            = directed_rows[r].sum;
            typed_res.clipped_sum_of_squares = directed_rows[r].sq;
            for (int k = 0; k < directed_rows[r].reps; k++)
            begin
                send_item(it, 0, directed_rows[r].typed, typed_res);
            end
        end
        drain();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_columns(phase_cols[p]);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                send_item(random_item(), phase_idle[p], 1'b0, '0);
            end
            drain();
        end

        if (fail_count == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
